// ===== hdl/i2crt_pkg.sv =====
// Shared types and constants for the I2C register target.
package i2crt_pkg;

  localparam int unsigned AddrW      = 7;
  localparam int unsigned ByteW      = 8;
  localparam int unsigned BitIdxW    = 4;
  localparam int unsigned ByteIdxW   = 2;
  localparam int unsigned CfgIndexW  = 8;

  localparam logic [AddrW-1:0]    FirstAddrReset  = 7'h42;
  localparam logic [AddrW-1:0]    SecondAddrReset = 7'h6F;
  localparam logic [BitIdxW-1:0]  AckSlot         = 4'd8;
  localparam logic [ByteIdxW-1:0] ByteAddr        = 2'd0;
  localparam logic [ByteIdxW-1:0] ByteOffset      = 2'd1;
  localparam logic [ByteIdxW-1:0] ByteData        = 2'd2;

  // Configuration register indexes
  localparam logic [CfgIndexW-1:0] CfgFirstAddr  = 8'd0;
  localparam logic [CfgIndexW-1:0] CfgSecondAddr = 8'd1;

  typedef struct packed {
    logic             scl_level;
    logic             sda_level;
    logic [ByteW-1:0] read_data;
  } in_item_t;

  typedef struct packed {
    logic             sda_drive;
    logic             write_strobe;
    logic [AddrW-1:0] write_device;
    logic [ByteW-1:0] write_offset;
    logic [ByteW-1:0] write_data;
    logic             fetch_strobe;
    logic [AddrW-1:0] fetch_device;
    logic [ByteW-1:0] fetch_offset;
  } out_item_t;

  typedef struct packed {
    logic [AddrW-1:0] first_target_address;
    logic [AddrW-1:0] second_target_address;
  } cfg_regs_t;

endpackage

// ===== hdl/i2crt_cfg.sv =====
// Configuration registers: the two acknowledged device addresses.
module i2crt_cfg (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                cfg_valid,
  input  logic [i2crt_pkg::CfgIndexW-1:0]     cfg_index,
  input  logic [i2crt_pkg::AddrW-1:0]         cfg_data,
  output i2crt_pkg::cfg_regs_t                regs
);

  i2crt_pkg::cfg_regs_t regs_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      regs_r.first_target_address  <= i2crt_pkg::FirstAddrReset;
      regs_r.second_target_address <= i2crt_pkg::SecondAddrReset;
    end else if (cfg_valid) begin
      // drop writes to unused indexes
      if (cfg_index == i2crt_pkg::CfgFirstAddr) begin
        regs_r.first_target_address <= cfg_data;
      end else if (cfg_index == i2crt_pkg::CfgSecondAddr) begin
        regs_r.second_target_address <= cfg_data;
      end
    end
  end

  assign regs = regs_r;

endmodule

// ===== hdl/i2crt_core.sv =====
// Bus state tracker: per-sample edge decode, shift register and byte protocol.
module i2crt_core (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  step,
  input  i2crt_pkg::in_item_t   sample,
  input  i2crt_pkg::cfg_regs_t  regs,
  output i2crt_pkg::out_item_t  result
);

  logic                               bus_idle_r, bus_idle_nxt;
  logic [i2crt_pkg::BitIdxW-1:0]      bit_index_r, bit_index_nxt;
  logic                               last_scl_r, last_scl_nxt;
  logic                               last_sda_r, last_sda_nxt;
  logic                               reading_r, reading_nxt;
  logic [i2crt_pkg::ByteW-1:0]        shift_byte_r, shift_byte_nxt;
  logic [i2crt_pkg::ByteIdxW-1:0]     byte_index_r, byte_index_nxt;
  logic [i2crt_pkg::AddrW-1:0]        target_address_r, target_address_nxt;
  logic [i2crt_pkg::ByteW-1:0]        register_offset_r, register_offset_nxt;
  logic                               sda_hold_r, sda_hold_nxt;
  i2crt_pkg::out_item_t               res;

  always_comb begin
    logic ack;
    logic scl;
    logic sda;
    scl = sample.scl_level;
    sda = sample.sda_level;
    ack = 1'b1;
    bus_idle_nxt        = bus_idle_r;
    bit_index_nxt       = bit_index_r;
    last_scl_nxt        = last_scl_r;
    last_sda_nxt        = last_sda_r;
    reading_nxt         = reading_r;
    shift_byte_nxt      = shift_byte_r;
    byte_index_nxt      = byte_index_r;
    target_address_nxt  = target_address_r;
    register_offset_nxt = register_offset_r;
    sda_hold_nxt        = sda_hold_r;
    res                 = '0;

    if (step && (scl != last_scl_r || sda != last_sda_r)) begin
      // start: both lines low while idle
      if (bus_idle_nxt && !scl && !sda) begin
        bus_idle_nxt  = 1'b0;
        bit_index_nxt = '0;
      end
      // stop: only recognized at bit index one
      if (!bus_idle_nxt && bit_index_nxt == 4'd1 && scl && sda && !last_sda_r) begin
        bus_idle_nxt   = 1'b1;
        byte_index_nxt = '0;
        reading_nxt    = 1'b0;
      end
      if (!bus_idle_nxt && scl && !last_scl_r) begin
        sda_hold_nxt = 1'b1;
        if (bit_index_nxt < i2crt_pkg::AckSlot) begin
          if (reading_nxt) begin
            if (bit_index_nxt == '0) begin
              shift_byte_nxt   = sample.read_data;
              res.fetch_strobe = 1'b1;
              res.fetch_device = target_address_nxt;
              res.fetch_offset = register_offset_nxt;
            end
            sda_hold_nxt   = shift_byte_nxt[i2crt_pkg::ByteW-1];
            shift_byte_nxt = {shift_byte_nxt[i2crt_pkg::ByteW-2:0], 1'b0};
          end else begin
            shift_byte_nxt = {shift_byte_nxt[i2crt_pkg::ByteW-2:0], sda};
          end
          bit_index_nxt = bit_index_nxt + 4'd1;
        end else begin
          if (reading_nxt) begin
            // controller NACK ends the read
            if (sda) begin
              byte_index_nxt = '0;
              reading_nxt    = 1'b0;
            end
          end else begin
            if (byte_index_nxt == i2crt_pkg::ByteAddr) begin
              target_address_nxt = shift_byte_nxt[i2crt_pkg::ByteW-1:1];
              reading_nxt        = shift_byte_nxt[0];
              if (target_address_nxt != regs.first_target_address &&
                  target_address_nxt != regs.second_target_address) begin
                ack = 1'b0;
              end
            end else if (byte_index_nxt == i2crt_pkg::ByteOffset) begin
              register_offset_nxt = shift_byte_nxt;
            end else begin
              res.write_strobe    = 1'b1;
              res.write_device    = target_address_nxt;
              res.write_offset    = register_offset_nxt;
              res.write_data      = shift_byte_nxt;
              register_offset_nxt = register_offset_nxt + 8'd1;
            end
            if (ack) begin
              sda_hold_nxt = 1'b0;
              if (byte_index_nxt < i2crt_pkg::ByteData) begin
                byte_index_nxt = byte_index_nxt + 2'd1;
              end
            end else begin
              byte_index_nxt = '0;
              reading_nxt    = 1'b0;
            end
          end
          bit_index_nxt = '0;
        end
      end
      last_scl_nxt = scl;
      last_sda_nxt = sda;
    end
    res.sda_drive = sda_hold_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      bus_idle_r        <= 1'b1;
      bit_index_r       <= '0;
      last_scl_r        <= 1'b0;
      last_sda_r        <= 1'b0;
      reading_r         <= 1'b0;
      shift_byte_r      <= '0;
      byte_index_r      <= '0;
      target_address_r  <= '0;
      register_offset_r <= '0;
      sda_hold_r        <= 1'b0;
    end else begin
      bus_idle_r        <= bus_idle_nxt;
      bit_index_r       <= bit_index_nxt;
      last_scl_r        <= last_scl_nxt;
      last_sda_r        <= last_sda_nxt;
      reading_r         <= reading_nxt;
      shift_byte_r      <= shift_byte_nxt;
      byte_index_r      <= byte_index_nxt;
      target_address_r  <= target_address_nxt;
      register_offset_r <= register_offset_nxt;
      sda_hold_r        <= sda_hold_nxt;
    end
  end

  assign result = res;

  a_bit_index_range: assert property (@(posedge clk) disable iff (!rst_n)
    bit_index_r <= i2crt_pkg::AckSlot)
    else $error("bit index beyond acknowledge slot");

  a_byte_index_sat: assert property (@(posedge clk) disable iff (!rst_n)
    byte_index_r <= i2crt_pkg::ByteData)
    else $error("byte index beyond saturation");

  a_strobe_excl: assert property (@(posedge clk) disable iff (!rst_n)
    !(res.write_strobe && res.fetch_strobe))
    else $error("write and fetch in the same sample");

  a_write_advance: assert property (@(posedge clk) disable iff (!rst_n)
    res.write_strobe |=> register_offset_r == $past(register_offset_r) + 8'd1)
    else $error("offset did not advance after write");

  a_fetch_reading: assert property (@(posedge clk) disable iff (!rst_n)
    res.fetch_strobe |-> reading_r && bit_index_r == '0)
    else $error("fetch outside a read byte start");

endmodule

// ===== hdl/i2c_register_target.sv =====
// Top level of the I2C register target: handshake pipeline around the bus tracker.
//
// Each input transfer carries one sample of SCL and SDA plus the byte that the
// register backend offers for the current device and offset; every accepted
// sample yields exactly one result transfer. One sample is taken per clock when
// the output side keeps up. A sample is captured in the input register on its
// input transfer and is loaded into the result register when that register is
// empty or being emptied; the result transfer is made from there. The
// bus state is updated as a sample moves from the input register into the
// result register, so the short decode logic between those two registers sets
// the rate. A full result register with out_ready low stalls the input side;
// in_ready stays high while the input register can still advance. The two
// acknowledged addresses are written through the cfg_ port (index 0 and 1,
// other indexes ignored), which is always ready; write them only while no
// samples are in flight.
module i2c_register_target (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  i2crt_pkg::in_item_t               in_item,
  output logic                              out_valid,
  input  logic                              out_ready,
  output i2crt_pkg::out_item_t              out_item,
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [i2crt_pkg::CfgIndexW-1:0]   cfg_index,
  input  logic [i2crt_pkg::AddrW-1:0]       cfg_data
);

  logic                  s1_valid_r;
  i2crt_pkg::in_item_t   s1_item_r;
  logic                  out_valid_r;
  i2crt_pkg::out_item_t  out_item_r;
  logic                  advance;
  i2crt_pkg::cfg_regs_t  regs;
  i2crt_pkg::out_item_t  core_result;

  // Advance the input register into the result register when the result
  // register is empty or its content is being transferred out this cycle.
  assign advance   = s1_valid_r && (!out_valid_r || out_ready);
  assign in_ready  = !s1_valid_r || advance;
  assign cfg_ready = 1'b1;

  i2crt_cfg u_cfg (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_valid (cfg_valid),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .regs      (regs)
  );

  // Bus state advances only on a sample that moves forward.
  i2crt_core u_core (
    .clk    (clk),
    .rst_n  (rst_n),
    .step   (advance),
    .sample (s1_item_r),
    .regs   (regs),
    .result (core_result)
  );

  // Input register: capture a sample on every input transfer.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (in_ready) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      s1_item_r <= in_item;
    end
  end

  // Result register: hold until the downstream side takes it.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (advance) begin
      out_valid_r <= 1'b1;
    end else if (out_ready) begin
      out_valid_r <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_item_r <= core_result;
    end
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_item_r;

  a_stall_holds_input: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !advance |=> s1_valid_r && $stable(s1_item_r))
    else $error("input register lost a sample while stalled");

  a_advance_needs_room: assert property (@(posedge clk) disable iff (!rst_n)
    advance |=> out_valid_r)
    else $error("advanced sample missing from result register");

  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r && !out_ready |-> !advance)
    else $error("result overwritten before transfer");

endmodule

// ===== verif/tb_i2c_register_target.sv =====
// Self-checking testbench for the I2C register target, driven with sampled bus traffic.
`timescale 1ns / 1ps

module tb_i2c_register_target;

  localparam int unsigned ClkHalf       = 10;
  localparam int unsigned ResetCycles   = 10;
  localparam int unsigned PipeDepth     = 2;
  localparam int unsigned MaxWait       = 16;
  localparam int unsigned RandomSamples = 60;
  localparam int unsigned RandomRounds  = 3;
  localparam longint      TimeoutNs     = 10_000_000;

  typedef logic [i2crt_pkg::ByteW-1:0]     byte_t;
  typedef logic [i2crt_pkg::AddrW-1:0]     addr_t;
  typedef logic [i2crt_pkg::BitIdxW-1:0]   bit_idx_t;
  typedef logic [i2crt_pkg::ByteIdxW-1:0]  byte_idx_t;
  typedef logic [i2crt_pkg::CfgIndexW-1:0] cfg_index_t;

  // Bus-level codes
  localparam logic DirWrite = 1'b0;
  localparam logic DirRead  = 1'b1;
  localparam logic AckBit   = 1'b0;
  localparam logic NackBit  = 1'b1;

  logic                  clk = 1'b0;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_ready;
  i2crt_pkg::in_item_t   in_item;
  logic                  out_valid;
  logic                  out_ready = 1'b0;
  i2crt_pkg::out_item_t  out_item;
  logic                  cfg_valid;
  logic                  cfg_ready;
  cfg_index_t            cfg_index;
  addr_t                 cfg_data;

  i2c_register_target DUT (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data)
  );

  always #(ClkHalf) clk = ~clk;

  // Predicted bus tracker state, advanced once per accepted sample.
  logic       m_idle;
  bit_idx_t   m_bit_cnt;
  logic       m_prev_scl;
  logic       m_prev_sda;
  logic       m_rd_mode;
  byte_t      m_shreg;
  byte_idx_t  m_byte_cnt;
  addr_t      m_dev;
  byte_t      m_offset;
  logic       m_sda_out;
  addr_t      m_addr_a;
  addr_t      m_addr_b;

  i2crt_pkg::out_item_t pending_bus_results[$];
  int unsigned samples_sent = 0;
  int unsigned error_count  = 0;
  int unsigned out_hold     = 0;
  bit          in_calm      = 1'b0;
  bit          out_calm     = 1'b0;

  function automatic logic rand_bit();
    return $urandom_range(0, 1) != 0;
  endfunction

  function automatic byte_t rand_byte();
    return byte_t'($urandom);
  endfunction

  function automatic addr_t rand_addr();
    return addr_t'($urandom);
  endfunction

  // Work out the result of one bus sample and advance the predicted state.
  function automatic i2crt_pkg::out_item_t track_bus(input i2crt_pkg::in_item_t s);
    i2crt_pkg::out_item_t r;
    logic                 ack;
    r = '0;
    if (s.scl_level != m_prev_scl || s.sda_level != m_prev_sda) begin
      // Start: both lines low while idle.
      if (m_idle && !s.scl_level && !s.sda_level) begin
        m_idle    = 1'b1 ^ 1'b1;
        m_bit_cnt = '0;
      end
      // Stop: SDA rising with SCL high, honored only right after the first bit edge.
      if (!m_idle && m_bit_cnt == bit_idx_t'(1) && s.scl_level && s.sda_level &&
          !m_prev_sda) begin
        m_idle     = 1'b1;
        m_byte_cnt = i2crt_pkg::ByteAddr;
        m_rd_mode  = 1'b0;
      end
      if (!m_idle && s.scl_level && !m_prev_scl) begin
        m_sda_out = 1'b1;
        if (m_bit_cnt < i2crt_pkg::AckSlot) begin
          if (m_rd_mode) begin
            // Fetch the backend byte on the first bit of each read byte.
            if (m_bit_cnt == '0) begin
              m_shreg        = s.read_data;
              r.fetch_strobe = 1'b1;
              r.fetch_device = m_dev;
              r.fetch_offset = m_offset;
            end
            m_sda_out = m_shreg[i2crt_pkg::ByteW-1];
            m_shreg   = {m_shreg[i2crt_pkg::ByteW-2:0], 1'b0};
          end else begin
            m_shreg = {m_shreg[i2crt_pkg::ByteW-2:0], s.sda_level};
          end
          m_bit_cnt = m_bit_cnt + bit_idx_t'(1);
        end else begin
          if (m_rd_mode) begin
            // Controller NACK ends the read; ACK keeps the offset where it is.
            if (s.sda_level) begin
              m_byte_cnt = i2crt_pkg::ByteAddr;
              m_rd_mode  = 1'b0;
            end
          end else begin
            ack = 1'b1;
            if (m_byte_cnt == i2crt_pkg::ByteAddr) begin
              m_dev     = m_shreg[i2crt_pkg::ByteW-1:1];
              m_rd_mode = m_shreg[0];
              if (m_dev != m_addr_a && m_dev != m_addr_b) ack = 1'b0;
            end else if (m_byte_cnt == i2crt_pkg::ByteOffset) begin
              m_offset = m_shreg;
            end else begin
              r.write_strobe = 1'b1;
              r.write_device = m_dev;
              r.write_offset = m_offset;
              r.write_data   = m_shreg;
              m_offset       = m_offset + byte_t'(1);
            end
            if (ack) begin
              m_sda_out = 1'b0;
              if (m_byte_cnt < i2crt_pkg::ByteData) m_byte_cnt = m_byte_cnt + byte_idx_t'(1);
            end else begin
              m_byte_cnt = i2crt_pkg::ByteAddr;
              m_rd_mode  = 1'b0;
            end
          end
          m_bit_cnt = '0;
        end
      end
      m_prev_scl = s.scl_level;
      m_prev_sda = s.sda_level;
    end
    r.sda_drive = m_sda_out;
    return r;
  endfunction

  task automatic report_mismatch(input string msg);
    error_count++;
    $display("[%0t] mismatch: %s", $realtime, msg);
  endtask

  task automatic check_field(input string name, input byte_t got, input byte_t want);
    if (got !== want)
      report_mismatch($sformatf("%s got 0x%0h, expected 0x%0h", name, got, want));
  endtask

  task automatic check_result(input i2crt_pkg::out_item_t got);
    i2crt_pkg::out_item_t want;
    if (pending_bus_results.size() == 0) begin
      report_mismatch("result transfer with no sample outstanding");
    end else begin
      want = pending_bus_results.pop_front();
      check_field("sda_drive",    byte_t'(got.sda_drive),    byte_t'(want.sda_drive));
      check_field("write_strobe", byte_t'(got.write_strobe), byte_t'(want.write_strobe));
      check_field("write_device", byte_t'(got.write_device), byte_t'(want.write_device));
      check_field("write_offset", got.write_offset,          want.write_offset);
      check_field("write_data",   got.write_data,            want.write_data);
      check_field("fetch_strobe", byte_t'(got.fetch_strobe), byte_t'(want.fetch_strobe));
      check_field("fetch_device", byte_t'(got.fetch_device), byte_t'(want.fetch_device));
      check_field("fetch_offset", got.fetch_offset,          want.fetch_offset);
    end
  endtask

  // Check every result transfer; draw the stall before the next one.
  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      check_result(out_item);
      if ($urandom_range(0, 31) == 0) out_calm = !out_calm;
      out_hold = out_calm ? 0 : $urandom_range(0, MaxWait);
    end
  end

  // Hold out_ready low for the drawn stall, then raise it until the next transfer.
  always @(negedge clk) begin
    if (out_hold != 0) begin
      out_ready = 1'b0;
      out_hold--;
    end else begin
      out_ready = 1'b1;
    end
  end

  // Present one bus sample after a random gap; predict its result on transfer.
  // Valid stays high into the next call so back-to-back samples need no gap.
  task automatic send_sample(input logic scl, input logic sda, input byte_t rd);
    int unsigned         gap;
    i2crt_pkg::in_item_t s;
    if ($urandom_range(0, 31) == 0) in_calm = !in_calm;
    gap         = in_calm ? 0 : $urandom_range(0, MaxWait);
    s.scl_level = scl;
    s.sda_level = sda;
    s.read_data = rd;
    @(negedge clk);
    if (gap != 0) begin
      in_valid = 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_item  = s;
    in_valid = 1'b1;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    pending_bus_results.push_back(track_bus(s));
    samples_sent++;
  endtask

  // Drop valid, wait for every predicted result, then let the pipeline settle.
  task automatic drain_bus();
    @(negedge clk);
    in_valid = 1'b0;
    while (pending_bus_results.size() != 0) @(posedge clk);
    repeat (PipeDepth + 2) @(posedge clk);
  endtask

  // Write one address register; call only with the pipeline drained.
  task automatic cfg_write(input cfg_index_t idx, input addr_t val);
    @(negedge clk);
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = val;
    @(posedge clk);
    while (!cfg_ready) @(posedge clk);
    if (idx == i2crt_pkg::CfgFirstAddr) m_addr_a = val;
    else if (idx == i2crt_pkg::CfgSecondAddr) m_addr_b = val;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  // Bus-level helpers: lower SCL and set the data bit, then raise SCL.
  task automatic bus_bit(input logic b, input byte_t rd);
    send_sample(1'b0, b, rd);
    send_sample(1'b1, b, rd);
  endtask

  task automatic bus_start();
    send_sample(1'b1, 1'b1, rand_byte());
    send_sample(1'b1, 1'b0, rand_byte());
    send_sample(1'b0, 1'b0, rand_byte());
  endtask

  // The rising edge here moves the bit index to one, where the stop is honored.
  task automatic bus_stop();
    send_sample(1'b0, 1'b0, rand_byte());
    send_sample(1'b1, 1'b0, rand_byte());
    send_sample(1'b1, 1'b1, rand_byte());
  endtask

  task automatic bus_send_byte(input byte_t b);
    for (int i = i2crt_pkg::ByteW - 1; i >= 0; i--) bus_bit(b[i], rand_byte());
    bus_bit(1'b1, rand_byte());
  endtask

  task automatic bus_read_byte(input byte_t rd, input logic ack_level);
    bus_bit(1'b1, rd);
    for (int i = 1; i < i2crt_pkg::ByteW; i++) bus_bit(1'b1, rand_byte());
    bus_bit(ack_level, rand_byte());
  endtask

  // Clock the bus until the predicted tracker is idle again.
  task automatic settle_to_idle();
    while (!m_idle) begin
      if (m_bit_cnt == '0) bus_stop();
      else bus_bit(rand_bit(), rand_byte());
    end
  endtask

  // Address, offset, then n data bytes; the first data byte is given.
  task automatic write_regs(input addr_t dev, input byte_t ofs,
                            input int unsigned n, input byte_t first_data);
    bus_start();
    bus_send_byte({dev, DirWrite});
    bus_send_byte(ofs);
    for (int unsigned k = 0; k < n; k++) bus_send_byte(k == 0 ? first_data : rand_byte());
    bus_stop();
  endtask

  // Read n bytes, ACK on all but the last; the backend offers first_rd first.
  task automatic read_regs(input addr_t dev, input int unsigned n, input byte_t first_rd);
    bus_start();
    bus_send_byte({dev, DirRead});
    for (int unsigned k = 0; k < n; k++)
      bus_read_byte(k == 0 ? first_rd : rand_byte(), k == n - 1 ? NackBit : AckBit);
    bus_stop();
  endtask

  function automatic addr_t pick_device();
    int unsigned roll;
    roll = $urandom_range(0, 9);
    if (roll < 4) return m_addr_a;
    if (roll < 8) return m_addr_b;
    return rand_addr();
  endfunction

  // Mostly well-formed transfers with random content; some noise and aborted ones.
  task automatic random_transaction();
    int unsigned kind;
    addr_t       dev;
    kind = $urandom_range(0, 19);
    dev  = pick_device();
    if (kind < 8) begin
      write_regs(dev, rand_byte(), $urandom_range(0, 3), rand_byte());
    end else if (kind < 15) begin
      write_regs(dev, rand_byte(), 0, rand_byte());
      read_regs(dev, $urandom_range(1, 3), rand_byte());
    end else if (kind < 17) begin
      repeat ($urandom_range(1, 6))
        send_sample(rand_bit(), rand_bit(), rand_byte());
    end else begin
      bus_start();
      repeat ($urandom_range(1, 20)) bus_bit(rand_bit(), rand_byte());
      if ($urandom_range(0, 1) == 0) bus_stop();
    end
    settle_to_idle();
  endtask

  // Reset addresses: writes with extreme data, then a read that ACKs once and NACKs.
  task automatic test_default_addresses();
    write_regs(i2crt_pkg::FirstAddrReset, 8'h00, 1, 8'h00);
    write_regs(i2crt_pkg::SecondAddrReset, 8'hFF, 1, 8'hFF);
    write_regs(i2crt_pkg::SecondAddrReset, 8'h10, 0, 8'h00);
    read_regs(i2crt_pkg::SecondAddrReset, 2, 8'hFF);
  endtask

  // Extreme addresses, a spare register index, offset wrap, byte count saturation,
  // and a device that is no longer acknowledged.
  task automatic test_address_config();
    drain_bus();
    cfg_write(i2crt_pkg::CfgFirstAddr, '0);
    cfg_write(i2crt_pkg::CfgSecondAddr, '1);
    cfg_write(i2crt_pkg::CfgSecondAddr + cfg_index_t'(1), rand_addr());
    write_regs('0, 8'hFF, 3, 8'hA5);
    write_regs('1, 8'h20, 0, 8'h00);
    read_regs('1, 1, 8'h00);
    write_regs(i2crt_pkg::FirstAddrReset, 8'h30, 1, 8'h55);
    read_regs(i2crt_pkg::SecondAddrReset, 1, 8'h5A);
  endtask

  // A stop pattern in the middle of a byte must be ignored.
  task automatic test_stop_placement();
    bus_start();
    bus_send_byte({m_addr_a, DirWrite});
    repeat (3) bus_bit(1'b0, rand_byte());
    bus_stop();
    settle_to_idle();
  endtask

  task automatic test_random_traffic();
    int unsigned goal;
    for (int round = 0; round < RandomRounds; round++) begin
      drain_bus();
      cfg_write(i2crt_pkg::CfgFirstAddr, rand_addr());
      cfg_write(i2crt_pkg::CfgSecondAddr, $urandom_range(0, 3) == 0 ? m_addr_a : rand_addr());
      if ($urandom_range(0, 1) == 0)
        cfg_write(cfg_index_t'($urandom_range(i2crt_pkg::CfgSecondAddr + 1,
                                              (1 << i2crt_pkg::CfgIndexW) - 1)),
                  rand_addr());
      goal = samples_sent + RandomSamples / RandomRounds;
      while (samples_sent < goal) random_transaction();
    end
  endtask

  initial begin
    rst_n      = 1'b0;
    in_valid   = 1'b0;
    in_item    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = i2crt_pkg::CfgFirstAddr;
    cfg_data   = '0;
    m_idle     = 1'b1;
    m_bit_cnt  = '0;
    m_prev_scl = 1'b0;
    m_prev_sda = 1'b0;
    m_rd_mode  = 1'b0;
    m_shreg    = '0;
    m_byte_cnt = i2crt_pkg::ByteAddr;
    m_dev      = '0;
    m_offset   = '0;
    m_sda_out  = 1'b0;
    m_addr_a   = i2crt_pkg::FirstAddrReset;
    m_addr_b   = i2crt_pkg::SecondAddrReset;
    repeat (ResetCycles) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;

    test_default_addresses();
    test_address_config();
    test_stop_placement();
    test_random_traffic();
    drain_bus();

    if (error_count == 0) begin
      $display("** i2c_register_target: PASSED **");
    end else begin
      $display("** i2c_register_target: FAILED **");
    end
    $finish;
  end

  // Abort a hung run.
  initial begin
    #(TimeoutNs);
    $display("** i2c_register_target: FAILED **");
    $finish;
  end

endmodule

// ===== filelist.f =====
hdl/i2crt_pkg.sv
hdl/i2crt_cfg.sv
hdl/i2crt_core.sv
hdl/i2c_register_target.sv
verif/tb_i2c_register_target.sv
